FILE: rtl/core/ordered_array_list_assert.svh
// ----------------------------------------------------------------------------
// Ordered array list: assertion macros
// Concurrent assertion wrappers shared by the RTL files; define NO_ASSERTIONS
// to compile them out.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_LIST_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset
`define OAL_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent
`define OAL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define OAL_ASSERT(name, clk, rst_n, prop, msg)
`define OAL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/core/oal_pkg.sv
// ----------------------------------------------------------------------------
// Ordered array list: package
// Command codes, field widths and the control and status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package oal_pkg;

  // Field widths
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned CAP_W   = 7;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned FIDX_W  = 6;

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned REG_IDX_LSB = 2;

  localparam logic [CAP_W-1:0] MIN_CAPACITY   = 7'd5;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

  // Register indexes
  typedef enum logic [0:0] {
    REG_CAPACITY = 1'b0
  } reg_idx_e;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR    = 3'd0,
    CMD_INSERT   = 3'd1,
    CMD_DELETE   = 3'd2,
    CMD_FIND     = 3'd3,
    CMD_RETRIEVE = 3'd4
  } cmd_e;

  // Controller to datapath
  typedef struct packed {
    logic latch;   // take in a new request
    logic check;   // range check, set up the walk bounds
    logic issue;   // read the entry at the walk address
    logic proc;    // act on the entry read in the cycle before
    logic commit;  // final write and length update
    logic load;    // load the result register
  } oal_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic walk;    // request needs a walk over the store
    logic at_end;  // walk address is the last one
    logic hit;     // find matched the entry just read
  } oal_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/oal_ram.sv
// ----------------------------------------------------------------------------
// Ordered array list: entry RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module oal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/oal_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered array list: controller
// Sequences one request at a time through check, walk, commit and result,
// and owns the valid/stall handshakes of both channels.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ordered_array_list_assert.svh"

module oal_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output oal_pkg::oal_ctrl_t     ctrl_o,
  input  wire oal_pkg::oal_stat_t stat_i
);

  import oal_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_WALK   = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_FINAL  = 6'b010000,
    ST_RESULT = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign accept     = (state_q == ST_IDLE) && in_valid_i;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Drive datapath commands from the state
  always_comb begin
    ctrl_o        = '0;
    ctrl_o.latch  = accept;
    ctrl_o.check  = (state_q == ST_CHECK);
    ctrl_o.issue  = (state_q == ST_WALK);
    ctrl_o.proc   = (state_q == ST_WALK) || (state_q == ST_DRAIN);
    ctrl_o.commit = (state_q == ST_FINAL);
    ctrl_o.load   = (state_q == ST_RESULT) && out_free;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = stat_i.walk ? ST_WALK : ST_FINAL;
      end
      ST_WALK: begin
        if (stat_i.hit) begin
          state_d = ST_FINAL;
        end else if (stat_i.at_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_FINAL;
      ST_FINAL:  state_d = ST_RESULT;
      ST_RESULT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Hold the result valid until the result is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `OAL_ASSERT(load_free_a, clk_i, rst_ni, !ctrl_o.load || !out_valid_q || !out_stall_i, "result loaded over a waiting one")
  `OAL_ASSERT_NEXT(accept_check_a, clk_i, rst_ni, accept, state_q == ST_CHECK, "accepted request not checked")

endmodule

`default_nettype wire

FILE: rtl/core/oal_dpath.sv
// ----------------------------------------------------------------------------
// Ordered array list: datapath
// Entry RAM, length register, range checks, the walk address pipeline and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ordered_array_list_assert.svh"

module oal_dpath #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire oal_pkg::oal_ctrl_t            ctrl_i,
  output oal_pkg::oal_stat_t                 stat_o,
  input  wire logic [oal_pkg::CAP_W-1:0]     cap_i,
  input  wire logic [oal_pkg::CMD_W-1:0]     command_i,
  input  wire logic signed [oal_pkg::VALUE_W-1:0] value_i,
  input  wire logic [oal_pkg::POS_W-1:0]     position_i,
  output logic signed [oal_pkg::VALUE_W-1:0] read_value_o,
  output logic                               found_o,
  output logic [oal_pkg::FIDX_W-1:0]         found_index_o,
  output logic                               error_o,
  output logic [oal_pkg::LEN_W-1:0]          length_o,
  output logic                               is_empty_o,
  output logic                               is_full_o
);

  import oal_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned KW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned EW = KW + 1;

  // Request registers
  logic [CMD_W-1:0]   cmd_q;
  logic [VALUE_W-1:0] val_q;
  logic [POS_W-1:0]   pos_q;

  // Control state
  logic [CW-1:0] count_q, count_d;
  logic          rd_pend_q;

  // Walk registers
  logic [AW-1:0] addr_q, end_q, rd_src_q;

  // Result scratch
  logic               err_q, found_q;
  logic [AW-1:0]      fidx_q;
  logic [VALUE_W-1:0] rval_q;

  // RAM port
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [VALUE_W-1:0] ram_rdata;

  // Extended operands for the checks
  logic [EW-1:0] n_x, p_x, capraw_x, cap_x, start_x, end_x, fidx_x;
  logic          full_c, pos_bad_c, err_c, walk_c, proc_c, hit_c;

  assign n_x      = EW'(count_q);
  assign p_x      = EW'(pos_q);
  assign capraw_x = EW'(cap_i);
  assign fidx_x   = EW'(fidx_q);

  // Clamp the capacity to the legal range
  always_comb begin
    cap_x = capraw_x;
    if (capraw_x < EW'(MIN_CAPACITY)) begin
      cap_x = EW'(MIN_CAPACITY);
    end else if (capraw_x > EW'(DEPTH)) begin
      cap_x = EW'(DEPTH);
    end
  end

  assign full_c    = (n_x >= cap_x);
  assign pos_bad_c = (p_x == '0) || (p_x > n_x);

  // Range check and walk bounds per command
  always_comb begin
    err_c   = 1'b0;
    walk_c  = 1'b0;
    start_x = '0;
    end_x   = '0;
    case (cmd_q)
      CMD_INSERT: begin
        err_c   = full_c || (p_x == '0) || (p_x > n_x + EW'(1));
        walk_c  = !err_c && (p_x <= n_x);
        start_x = n_x - EW'(1);
        end_x   = p_x - EW'(1);
      end
      CMD_DELETE: begin
        err_c   = pos_bad_c;
        walk_c  = !err_c && (p_x < n_x);
        start_x = p_x;
        end_x   = n_x - EW'(1);
      end
      CMD_FIND: begin
        walk_c  = (n_x != '0);
        end_x   = n_x - EW'(1);
      end
      CMD_RETRIEVE: begin
        err_c   = pos_bad_c;
        walk_c  = !err_c;
        start_x = p_x - EW'(1);
        end_x   = p_x - EW'(1);
      end
      default: begin
        err_c  = 1'b0;
        walk_c = 1'b0;
      end
    endcase
  end

  assign proc_c = ctrl_i.proc && rd_pend_q;
  assign hit_c  = proc_c && (cmd_q == CMD_FIND) && (ram_rdata == val_q);

  assign stat_o.walk   = walk_c;
  assign stat_o.at_end = (addr_q == end_q);
  assign stat_o.hit    = hit_c;

  // Move entries during the walk, place the new value at commit
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_src_q;
    ram_wdata = ram_rdata;
    if (proc_c && (cmd_q == CMD_INSERT)) begin
      ram_we    = 1'b1;
      ram_waddr = rd_src_q + AW'(1);
    end else if (proc_c && (cmd_q == CMD_DELETE)) begin
      ram_we    = 1'b1;
      ram_waddr = rd_src_q - AW'(1);
    end else if (ctrl_i.commit && !err_q && (cmd_q == CMD_INSERT)) begin
      ram_we    = 1'b1;
      ram_waddr = end_x[AW-1:0];
      ram_wdata = val_q;
    end
  end

  // Length update at commit
  always_comb begin
    count_d = count_q;
    if (ctrl_i.commit && !err_q) begin
      case (cmd_q)
        CMD_CLEAR:  count_d = '0;
        CMD_INSERT: count_d = count_q + CW'(1);
        CMD_DELETE: count_d = count_q - CW'(1);
        default:    count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      rd_pend_q <= ctrl_i.issue;
    end
  end

  // Latch the request and clear the result scratch
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q   <= command_i;
      val_q   <= value_i;
      pos_q   <= position_i;
      err_q   <= 1'b0;
      found_q <= 1'b0;
      fidx_q  <= '0;
      rval_q  <= '0;
    end else begin
      if (ctrl_i.check) begin
        err_q <= err_c;
      end
      if (hit_c && !found_q) begin
        found_q <= 1'b1;
        fidx_q  <= rd_src_q;
      end
      if (proc_c && (cmd_q == CMD_RETRIEVE)) begin
        rval_q <= ram_rdata;
      end
    end
  end

  // Walk address: down for insert, up otherwise
  always_ff @(posedge clk_i) begin
    if (ctrl_i.check) begin
      addr_q <= start_x[AW-1:0];
      end_q  <= end_x[AW-1:0];
    end else if (ctrl_i.issue) begin
      addr_q <= (cmd_q == CMD_INSERT) ? addr_q - AW'(1) : addr_q + AW'(1);
    end
    if (ctrl_i.issue) begin
      rd_src_q <= addr_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      read_value_o  <= rval_q;
      found_o       <= found_q;
      found_index_o <= fidx_x[FIDX_W-1:0];
      error_o       <= err_q;
      length_o      <= n_x[LEN_W-1:0];
      is_empty_o    <= (count_q == '0);
      is_full_o     <= full_c;
    end
  end

  oal_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctrl_i.issue),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  `OAL_ASSERT(we_phase_a, clk_i, rst_ni, !ram_we || ctrl_i.proc || ctrl_i.commit, "RAM written outside walk or commit")
  `OAL_ASSERT(count_bound_a, clk_i, rst_ni, count_q <= CW'(DEPTH), "length beyond store depth")
  `OAL_ASSERT_NEXT(insert_len_a, clk_i, rst_ni, ctrl_i.commit && !err_q && (cmd_q == CMD_INSERT), count_q == $past(count_q) + CW'(1), "insert did not grow the list")

endmodule

`default_nettype wire

FILE: rtl/core/ordered_array_list.sv
// ----------------------------------------------------------------------------
// Ordered array list: top level
// Ordered list of signed 32-bit entries with clear, insert, delete, find and
// retrieve requests, plus an APB-style capacity register.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake                 Payload
//   -------  ------------------------  -------------------------------------
//   in       in_valid_i / in_stall_o   command_i, value_i, position_i
//   out      out_valid_o / out_stall_i read_value_o, found_o, found_index_o,
//                                      error_o, length_o, is_empty_o,
//                                      is_full_o
//   cfg      psel / penable / pready   paddr, pwdata, prdata
//
// One request at a time, through check, walk, final and result; the walk is
// skipped when no entry is moved, searched or read, and covers at most the list length.
// The walk reads one entry per cycle through the single read port of the
// entry RAM; insert and delete write it to the neighbouring address in the next cycle.
// Reset clears the length and sets the capacity register to 64; the entry
// RAM keeps its contents, and no entry is read before it has been written.
// A stalled result stays in the output register while the next request is
// taken in; a second finished result waits until the first is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_array_list #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Request channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [oal_pkg::CMD_W-1:0]          command_i,
  input  wire logic signed [oal_pkg::VALUE_W-1:0] value_i,
  input  wire logic [oal_pkg::POS_W-1:0]          position_i,
  // Result channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [oal_pkg::VALUE_W-1:0]      read_value_o,
  output logic                                    found_o,
  output logic [oal_pkg::FIDX_W-1:0]              found_index_o,
  output logic                                    error_o,
  output logic [oal_pkg::LEN_W-1:0]               length_o,
  output logic                                    is_empty_o,
  output logic                                    is_full_o,
  // Configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [oal_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [oal_pkg::PDATA_W-1:0]        pwdata,
  output logic [oal_pkg::PDATA_W-1:0]             prdata,
  output logic                                    pready
);

  import oal_pkg::*;

  logic [CAP_W-1:0] cap_q;
  logic             cfg_wr;
  logic             cap_sel;
  oal_ctrl_t        ctrl;
  oal_stat_t        stat;

  // Capacity register
  assign pready  = 1'b1;
  assign cap_sel = (paddr[REG_IDX_LSB] == REG_CAPACITY);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAPACITY_RESET;
    end else if (cfg_wr && cap_sel) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = cap_sel ? PDATA_W'(cap_q) : '0;

  oal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl),
    .stat_i      (stat)
  );

  oal_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .cap_i         (cap_q),
    .command_i     (command_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .read_value_o  (read_value_o),
    .found_o       (found_o),
    .found_index_o (found_index_o),
    .error_o       (error_o),
    .length_o      (length_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

endmodule

`default_nettype wire

FILE: bench/ordered_array_list_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered array list: testbench
// Feeds directed and random list requests with random gaps and result stalls,
// predicts each result from a behavioural copy of the list and checks every
// field. The capacity register is moved through its extremes between phases.
// ----------------------------------------------------------------------------

module ordered_array_list_test;
  import oal_pkg::*;

  localparam int unsigned LIST_DEPTH = 64;
  localparam int unsigned POS_MAX = (1 << POS_W) - 1;
  localparam int unsigned CAP_MAX = (1 << CAP_W) - 1;
  localparam int unsigned MAX_GAP = 8;
  localparam int unsigned POOL_SIZE = 16;
  localparam int unsigned SETTLE_CYCLES = LIST_DEPTH + 16;
  localparam int unsigned MAX_REPORTS = 100;
  localparam int unsigned CAPACITY_ADDR = int'(REG_CAPACITY) << REG_IDX_LSB;
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST = 3'd7;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = ~VALUE_MIN;
  localparam logic signed [VALUE_W-1:0] VALUE_ONES = '1;

  typedef struct {
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    int unsigned               gap;
  } list_request_t;

  typedef struct {
    logic signed [VALUE_W-1:0] read_value;
    logic                      found;
    logic [FIDX_W-1:0]         found_index;
    logic                      error;
    logic [LEN_W-1:0]          length;
    logic                      is_empty;
    logic                      is_full;
  } list_result_t;

  // Block ports
  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [CMD_W-1:0]          command_i = '0;
  logic signed [VALUE_W-1:0] value_i = '0;
  logic [POS_W-1:0]          position_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [VALUE_W-1:0] read_value_o;
  logic                      found_o;
  logic [FIDX_W-1:0]         found_index_o;
  logic                      error_o;
  logic [LEN_W-1:0]          length_o;
  logic                      is_empty_o;
  logic                      is_full_o;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [PADDR_W-1:0]        paddr = '0;
  logic [PDATA_W-1:0]        pwdata = '0;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;

  // Predicted list state
  logic signed [VALUE_W-1:0] model_entries [LIST_DEPTH];
  int unsigned               model_len = 0;
  logic [CAP_W-1:0]          model_capacity = CAPACITY_RESET;

  // Request and result stores
  list_request_t             queued_requests [$];
  list_result_t              awaited_results [$];

  // Stimulus shaping
  int unsigned               gen_len = 0;
  int unsigned               gen_cap = LIST_DEPTH;
  int unsigned               send_calm = 0;
  logic signed [VALUE_W-1:0] value_pool [POOL_SIZE];

  // Handshake and pacing state
  logic                      req_taken = 1'b0;
  logic                      res_taken = 1'b0;
  int unsigned               gap_left = 0;
  logic                      gap_armed = 1'b0;
  int unsigned               stall_left = 0;
  int unsigned               stall_calm = 0;

  // Run statistics
  int unsigned               mismatches = 0;
  int unsigned               requests_seen = 0;
  int unsigned               results_checked = 0;
  int unsigned               refused_count = 0;
  int unsigned               full_count = 0;
  int unsigned               match_count = 0;
  int unsigned               capacity_writes = 0;

  ordered_array_list #(
    .DEPTH(LIST_DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o),
    .found_o      (found_o),
    .found_index_o(found_index_o),
    .error_o      (error_o),
    .length_o     (length_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Clamp the capacity register into the usable range
  function automatic int unsigned usable_capacity(logic [CAP_W-1:0] cap);
    if (cap < MIN_CAPACITY) return MIN_CAPACITY;
    if (cap > LIST_DEPTH) return LIST_DEPTH;
    return cap;
  endfunction

  // Apply one request to the predicted list and return its result
  function automatic list_result_t apply_request(list_request_t req);
    list_result_t res;
    int unsigned cap;
    int unsigned pos;
    res = '{default: '0};
    cap = usable_capacity(model_capacity);
    pos = req.position;
    case (req.command)
      CMD_CLEAR: begin
        model_len = 0;
      end
      CMD_INSERT: begin
        if (model_len >= cap || pos < 1 || pos > model_len + 1) begin
          res.error = 1'b1;
        end else begin
          for (int unsigned i = model_len; i >= pos; i--)
            model_entries[i] = model_entries[i-1];
          model_entries[pos-1] = req.value;
          model_len++;
        end
      end
      CMD_DELETE: begin
        if (pos < 1 || pos > model_len) begin
          res.error = 1'b1;
        end else begin
          for (int unsigned i = pos; i < model_len; i++)
            model_entries[i-1] = model_entries[i];
          model_len--;
        end
      end
      CMD_FIND: begin
        // plain search: the first equal entry wins
        for (int unsigned i = 0; i < model_len; i++) begin
          if (model_entries[i] == req.value) begin
            res.found = 1'b1;
            res.found_index = FIDX_W'(i);
            break;
          end
        end
      end
      CMD_RETRIEVE: begin
        if (pos < 1 || pos > model_len) res.error = 1'b1;
        else res.read_value = model_entries[pos-1];
      end
      default: begin
      end
    endcase
    res.length = LEN_W'(model_len);
    res.is_empty = (model_len == 0);
    res.is_full = (model_len >= cap);
    return res;
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                 logic [VALUE_W-1:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch at result %0d: got %h, want %h",
               $time, what, results_checked, got, want);
  endtask

  // Mostly values from a small pool so that finds hit, some extremes, some noise
  function automatic logic signed [VALUE_W-1:0] draw_value();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (pick == 6) return ($urandom_range(0, 1) != 0) ? VALUE_MIN : VALUE_MAX;
    return $urandom();
  endfunction

  // Position in 1..top mostly, otherwise zero or past the end
  function automatic int unsigned draw_position(int unsigned top);
    if (top == 0 || $urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) == 0) return 0;
      return $urandom_range(top + 1, POS_MAX);
    end
    return $urandom_range(1, top);
  endfunction

  // Queue one request with its lead-in gap and follow the list length
  function automatic void queue_request(logic [CMD_W-1:0] cmd,
                                        logic signed [VALUE_W-1:0] val,
                                        int unsigned pos);
    list_request_t req;
    req.command = cmd;
    req.value = val;
    req.position = POS_W'(pos);
    if (send_calm != 0) begin
      send_calm--;
      req.gap = 0;
    end else begin
      if ($urandom_range(0, 19) == 0) send_calm = $urandom_range(10, 40);
      req.gap = $urandom_range(0, MAX_GAP);
    end
    case (cmd)
      CMD_CLEAR: gen_len = 0;
      CMD_INSERT: if (gen_len < gen_cap && pos >= 1 && pos <= gen_len + 1) gen_len++;
      CMD_DELETE: if (pos >= 1 && pos <= gen_len) gen_len--;
      default: ;
    endcase
    queued_requests.push_back(req);
  endfunction

  // Queue a random mix; grow_pct sets the share of inserts
  function automatic void queue_random(int unsigned count, int unsigned grow_pct);
    int unsigned pick;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 1)
        queue_request(CMD_CLEAR, draw_value(), $urandom_range(0, POS_MAX));
      else if (pick < 3)
        queue_request(CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                      draw_value(), $urandom_range(0, POS_MAX));
      else if (pick < 3 + grow_pct)
        queue_request(CMD_INSERT, draw_value(), draw_position(gen_len + 1));
      else if (pick < 18 + grow_pct)
        queue_request(CMD_FIND, draw_value(), $urandom_range(0, POS_MAX));
      else if (pick < 33 + grow_pct)
        queue_request(CMD_RETRIEVE, draw_value(), draw_position(gen_len));
      else
        queue_request(CMD_DELETE, draw_value(), draw_position(gen_len));
    end
  endfunction

  // Hold until every queued request is taken and every result has come
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while (queued_requests.size() != 0 || in_valid_i || awaited_results.size() != 0);
  endtask

  // Write the capacity register, then read it back
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    logic [PDATA_W-1:0] upper;
    wait_idle();
    upper = $urandom();
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(CAPACITY_ADDR);
    pwdata <= {upper[PDATA_W-1:CAP_W], cap};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    gen_cap = usable_capacity(cap);
    capacity_writes++;
  endtask

  // Free-running clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Request driver: present the next request once its gap has run out
  always @(negedge clk_i) begin : drive_requests
    list_request_t req;
    if (rst_ni && !(in_valid_i && !req_taken)) begin
      if (queued_requests.size() != 0 && !gap_armed) begin
        gap_left = queued_requests[0].gap;
        gap_armed = 1'b1;
      end
      if (queued_requests.size() != 0 && gap_left == 0) begin
        req = queued_requests.pop_front();
        gap_armed = 1'b0;
        in_valid_i <= 1'b1;
        command_i <= req.command;
        value_i <= req.value;
        position_i <= req.position;
      end else begin
        in_valid_i <= 1'b0;
        if (gap_left != 0) gap_left--;
      end
    end
  end

  // Result stall: draw a stall per result, with calm stretches now and then
  always @(negedge clk_i) begin : drive_stall
    if (res_taken) begin
      if (stall_calm != 0) begin
        stall_calm--;
        stall_left = 0;
      end else begin
        if ($urandom_range(0, 15) == 0) stall_calm = $urandom_range(10, 40);
        stall_left = $urandom_range(0, MAX_GAP);
      end
    end
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0 && out_valid_o) stall_left--;
  end

  // Monitor: predict taken requests, check taken results, follow the register
  always @(posedge clk_i) begin : watch_ports
    list_request_t seen;
    list_result_t got;
    list_result_t want;
    if (!rst_ni) begin
      req_taken <= 1'b0;
      res_taken <= 1'b0;
    end else begin
      req_taken <= in_valid_i && !in_stall_o;
      res_taken <= out_valid_o && !out_stall_i;

      // Register access
      if (psel && penable && pready && paddr == PADDR_W'(CAPACITY_ADDR)) begin
        if (pwrite) model_capacity = pwdata[CAP_W-1:0];
        else if (prdata[CAP_W-1:0] !== model_capacity)
          report_mismatch("capacity readback", prdata, model_capacity);
      end

      // Accepted request
      if (in_valid_i && !in_stall_o) begin
        seen.command = command_i;
        seen.value = value_i;
        seen.position = position_i;
        seen.gap = 0;
        awaited_results.push_back(apply_request(seen));
        requests_seen++;
      end

      // Accepted result
      if (out_valid_o && !out_stall_i) begin
        got = '{read_value_o, found_o, found_index_o, error_o, length_o,
                is_empty_o, is_full_o};
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result", got.length, '0);
        end else begin
          want = awaited_results.pop_front();
          if (got.read_value !== want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
          if (got.found !== want.found)
            report_mismatch("found", got.found, want.found);
          if (got.found_index !== want.found_index)
            report_mismatch("found_index", got.found_index, want.found_index);
          if (got.error !== want.error)
            report_mismatch("error", got.error, want.error);
          if (got.length !== want.length)
            report_mismatch("length", got.length, want.length);
          if (got.is_empty !== want.is_empty)
            report_mismatch("is_empty", got.is_empty, want.is_empty);
          if (got.is_full !== want.is_full)
            report_mismatch("is_full", got.is_full, want.is_full);
          refused_count += want.error;
          full_count += want.is_full;
          match_count += want.found;
        end
        results_checked++;
      end
    end
  end

  // Stimulus and run control
  initial begin
    foreach (value_pool[k]) value_pool[k] = $urandom();
    value_pool[0] = VALUE_MIN;
    value_pool[1] = VALUE_MAX;
    value_pool[2] = '0;
    value_pool[3] = VALUE_ONES;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty list, edges of the position range, duplicates, spare codes
    queue_request(CMD_RETRIEVE, '0, 1);
    queue_request(CMD_DELETE, '0, 1);
    queue_request(CMD_FIND, '0, 0);
    queue_request(CMD_INSERT, VALUE_MAX, 0);
    queue_request(CMD_INSERT, VALUE_MAX, 2);
    queue_request(CMD_INSERT, VALUE_MIN, 1);
    queue_request(CMD_INSERT, VALUE_MAX, 2);
    queue_request(CMD_INSERT, VALUE_ONES, 1);
    queue_request(CMD_INSERT, '0, 4);
    queue_request(CMD_INSERT, '0, POS_MAX);
    queue_request(CMD_INSERT, VALUE_ONES, 3);
    queue_request(CMD_FIND, VALUE_ONES, 0);
    queue_request(CMD_FIND, VALUE_MAX, POS_MAX);
    queue_request(CMD_FIND, 32'sd12345, 0);
    queue_request(CMD_RETRIEVE, '0, 5);
    queue_request(CMD_RETRIEVE, '0, 6);
    queue_request(CMD_RETRIEVE, '0, 0);
    queue_request(CMD_DELETE, '0, 1);
    queue_request(CMD_FIND, VALUE_ONES, 0);
    queue_request(CMD_DELETE, '0, 4);
    queue_request(CMD_DELETE, '0, 0);
    queue_request(CMD_DELETE, '0, POS_MAX);
    for (int unsigned c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
      queue_request(CMD_W'(c), VALUE_ONES, POS_MAX);
    queue_request(CMD_CLEAR, VALUE_ONES, POS_MAX);
    queue_request(CMD_RETRIEVE, '0, 1);

    // Smallest capacity, then below the minimum
    write_capacity(CAP_W'(MIN_CAPACITY));
    queue_random(120, 50);
    write_capacity('0);
    queue_random(60, 40);

    // Above the store depth: fill the whole store
    write_capacity(CAP_W'(CAP_MAX));
    queue_random(220, 65);

    // Capacity below the current length: inserts refused until it drains
    write_capacity(CAP_W'(LIST_DEPTH));
    while (gen_len < 40) queue_request(CMD_INSERT, draw_value(), draw_position(gen_len + 1));
    write_capacity(CAP_W'(20));
    queue_random(140, 15);
    write_capacity(CAP_W'(MIN_CAPACITY - 1));
    queue_random(60, 30);

    // Random capacities
    for (int p = 0; p < 3; p++) begin
      write_capacity(CAP_W'($urandom_range(0, CAP_MAX)));
      queue_random(90, $urandom_range(20, 65));
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("ordered_array_list_test: %0d requests, %0d results compared, %0d refused",
             requests_seen, results_checked, refused_count);
    $display("ordered_array_list_test: %0d capacity writes, %0d full-list results, %0d finds hit",
             capacity_writes, full_count, match_count);
    if (mismatches == 0) begin
      $display("ordered_array_list_test: done, clean");
    end else begin
      $display("ordered_array_list_test: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("ordered_array_list_test: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/oal_pkg.sv
rtl/core/oal_ram.sv
rtl/core/oal_ctrl.sv
rtl/core/oal_dpath.sv
rtl/core/ordered_array_list.sv
bench/ordered_array_list_test.sv
